// ===== rtl/core/lhbf_pkg.sv =====
// Package for the LED heartbeat and burst flasher unit.
// Holds register reset values, register indexes and item command codes.
// No dependencies; used by every module of the block.
`default_nettype none

package lhbf_pkg;

    localparam int unsigned CfgWidth   = 16;
    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned CodeWidth  = 24;
    localparam int unsigned KindWidth  = 8;

    localparam logic [CfgWidth-1:0] BurstLengthReset = 16'd500;
    localparam logic [CfgWidth-1:0] BurstToggleReset = 16'd40;
    localparam logic [CfgWidth-1:0] PulseOnReset     = 16'd100;
    localparam logic [CfgWidth-1:0] PulseGapReset    = 16'd1000;

    typedef enum logic [1:0] {
        CFG_BURST_LENGTH = 2'd0,
        CFG_BURST_TOGGLE = 2'd1,
        CFG_PULSE_ON     = 2'd2,
        CFG_PULSE_GAP    = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_TAG  = 1'b1
    } command_t;

    // Tag checker verdict handed to the top level.
    typedef struct packed {
        logic kind_ok;
        logic codes_ok;
        logic good;
    } tag_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/lhbf_tag_check.sv =====
// Well-formedness check of one snapshot tag.
// Depends on lhbf_pkg for field widths and the status struct.
`default_nettype none

module lhbf_tag_check (
    input  wire logic [lhbf_pkg::KindWidth-1:0] tag_kind,
    input  wire logic [lhbf_pkg::CodeWidth-1:0] camp_code,
    input  wire logic [lhbf_pkg::CodeWidth-1:0] color_code,
    input  wire logic [lhbf_pkg::CodeWidth-1:0] rune_code,
    output lhbf_pkg::tag_status_t               status
);
    import lhbf_pkg::*;

    // A code is good when its two low bytes are nonzero and its top byte is zero.
    function automatic logic code_ok(input logic [CodeWidth-1:0] code);
        return (code[7:0] != 8'd0) && (code[15:8] != 8'd0) && (code[23:16] == 8'd0);
    endfunction

    always_comb
    begin
        status.kind_ok  = (tag_kind != '0);
        status.codes_ok = code_ok(camp_code) && code_ok(color_code) && code_ok(rune_code);
        status.good     = status.kind_ok && status.codes_ok;
    end

endmodule

`default_nettype wire

// ===== rtl/core/led_heartbeat_and_burst_flasher_unit.sv =====
// Top level of the LED heartbeat and burst flasher unit.
// Depends on lhbf_pkg and instantiates lhbf_tag_check.
`default_nettype none

// The block drives one status LED from a stream of items. A tick item
// (command 0) advances the millisecond clock and runs the burst flasher and
// then the heartbeat. A tag item (command 1) carries one snapshot entry; the
// last tag of a snapshot that held any well-formed tag restarts the burst.
// Every item yields one result transfer with the LED level and burst flag.
//
// Both item channels use valid/stall; a transfer happens on a rising edge
// with valid high and stall low. Items pass an input register, one pass of
// compare-and-add logic that also updates the state, and a result register.
// Result valid is registered: an item passes the input register and then
// the result register before its result transfer. One item is taken every
// cycle while the receiver does not stall. When the receiver stalls, the
// result register holds, the input register fills behind it, and in_stall
// rises only once both are full.
//
// The configuration channel uses valid/ready and is always ready; a write
// to a register index takes effect on the edge of its transfer. Writes
// are to be made while the block is idle; the block does not enforce it.
// Async reset (rst_n low) clears time, burst, heartbeat state; loads defaults.

module led_heartbeat_and_burst_flasher_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic                              command,
    input  wire logic [lhbf_pkg::KindWidth-1:0]    tag_kind,
    input  wire logic [lhbf_pkg::CodeWidth-1:0]    camp_code,
    input  wire logic [lhbf_pkg::CodeWidth-1:0]    color_code,
    input  wire logic [lhbf_pkg::CodeWidth-1:0]    rune_code,
    input  wire logic                              last_tag,

    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic                              led_level,
    output      logic                              burst_active,

    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [lhbf_pkg::CfgWidth-1:0]     cfg_data
);
    import lhbf_pkg::*;

    // Configuration registers.
    logic [CfgWidth-1:0] burst_length_reg;
    logic [CfgWidth-1:0] burst_toggle_reg;
    logic [CfgWidth-1:0] pulse_on_reg;
    logic [CfgWidth-1:0] pulse_gap_reg;

    // Input register.
    logic                 in_full_reg;
    logic                 command_reg;
    logic [KindWidth-1:0] tag_kind_reg;
    logic [CodeWidth-1:0] camp_code_reg;
    logic [CodeWidth-1:0] color_code_reg;
    logic [CodeWidth-1:0] rune_code_reg;
    logic                 last_tag_reg;

    // Block state.
    logic [TimeWidth-1:0] ms_now_reg,      ms_now_next;
    logic                 burst_on_reg,    burst_on_next;
    logic [TimeWidth-1:0] burst_end_reg,   burst_end_next;
    logic [TimeWidth-1:0] next_toggle_reg, next_toggle_next;
    logic [TimeWidth-1:0] beat_due_reg,    beat_due_next;
    logic                 beat_phase_reg,  beat_phase_next;
    logic                 led_pin_reg,     led_pin_next;
    logic                 seen_good_reg,   seen_good_next;

    // Result register.
    logic out_valid_reg;
    logic led_level_reg;
    logic burst_active_reg;

    logic        in_accept;
    logic        advance;
    tag_status_t tag_status;
    cfg_index_t  cfg_sel;

    logic [TimeWidth-1:0] now_inc;
    logic [TimeWidth-1:0] end_diff;
    logic [TimeWidth-1:0] toggle_diff;
    logic [TimeWidth-1:0] beat_diff;

    // The item in the input register moves on when the result register is
    // empty or is being taken on this edge.
    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = cfg_index_t'(cfg_index);

    assign out_valid    = out_valid_reg;
    assign led_level    = led_level_reg;
    assign burst_active = burst_active_reg;

    lhbf_tag_check u_tag_check (
        .tag_kind   (tag_kind_reg),
        .camp_code  (camp_code_reg),
        .color_code (color_code_reg),
        .rune_code  (rune_code_reg),
        .status     (tag_status)
    );

    // One pass over the state for the item in the input register. A deadline
    // counts as reached when the wrapping difference now - deadline has its
    // sign bit clear.
    always_comb
    begin
        ms_now_next      = ms_now_reg;
        burst_on_next    = burst_on_reg;
        burst_end_next   = burst_end_reg;
        next_toggle_next = next_toggle_reg;
        beat_due_next    = beat_due_reg;
        beat_phase_next  = beat_phase_reg;
        led_pin_next     = led_pin_reg;
        seen_good_next   = seen_good_reg;

        now_inc     = ms_now_reg + 32'd1;
        end_diff    = now_inc - burst_end_reg;
        toggle_diff = now_inc - next_toggle_reg;

        if (command_reg == CMD_TICK)
        begin
            ms_now_next = now_inc;
            if (burst_on_reg)
            begin
                if (!end_diff[TimeWidth-1])
                begin
                    burst_on_next    = 1'b0;
                    next_toggle_next = '0;
                    led_pin_next     = 1'b0;
                end
                else if (!toggle_diff[TimeWidth-1])
                begin
                    led_pin_next     = !led_pin_reg;
                    next_toggle_next = now_inc + {16'd0, burst_toggle_reg};
                end
            end
        end
        else
        begin
            seen_good_next = seen_good_reg || tag_status.good;
            if (last_tag_reg)
            begin
                if (seen_good_next)
                begin
                    burst_on_next    = 1'b1;
                    burst_end_next   = ms_now_reg + {16'd0, burst_length_reg};
                    next_toggle_next = ms_now_reg;
                end
                seen_good_next = 1'b0;
            end
        end

        // The heartbeat runs on ticks with no burst, including the tick on
        // which a burst has just ended.
        beat_diff = now_inc - beat_due_reg;
        if ((command_reg == CMD_TICK) && !burst_on_next && !beat_diff[TimeWidth-1])
        begin
            if (!beat_phase_reg)
            begin
                led_pin_next    = 1'b1;
                beat_due_next   = now_inc + {16'd0, pulse_on_reg};
                beat_phase_next = 1'b1;
            end
            else
            begin
                led_pin_next    = 1'b0;
                beat_due_next   = now_inc + {16'd0, pulse_gap_reg};
                beat_phase_next = 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_length_reg <= BurstLengthReset;
            burst_toggle_reg <= BurstToggleReset;
            pulse_on_reg     <= PulseOnReset;
            pulse_gap_reg    <= PulseGapReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_sel)
                CFG_BURST_LENGTH: burst_length_reg <= cfg_data;
                CFG_BURST_TOGGLE: burst_toggle_reg <= cfg_data;
                CFG_PULSE_ON:     pulse_on_reg     <= cfg_data;
                CFG_PULSE_GAP:    pulse_gap_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    // Input payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            command_reg    <= command;
            tag_kind_reg   <= tag_kind;
            camp_code_reg  <= camp_code;
            color_code_reg <= color_code;
            rune_code_reg  <= rune_code;
            last_tag_reg   <= last_tag;
        end
    end

    // Block state, updated as the item moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_now_reg      <= '0;
            burst_on_reg    <= 1'b0;
            burst_end_reg   <= '0;
            next_toggle_reg <= '0;
            beat_due_reg    <= '0;
            beat_phase_reg  <= 1'b0;
            led_pin_reg     <= 1'b0;
            seen_good_reg   <= 1'b0;
        end
        else if (advance)
        begin
            ms_now_reg      <= ms_now_next;
            burst_on_reg    <= burst_on_next;
            burst_end_reg   <= burst_end_next;
            next_toggle_reg <= next_toggle_next;
            beat_due_reg    <= beat_due_next;
            beat_phase_reg  <= beat_phase_next;
            led_pin_reg     <= led_pin_next;
            seen_good_reg   <= seen_good_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            led_level_reg    <= led_pin_next;
            burst_active_reg <= burst_on_next;
        end
    end

endmodule

`default_nettype wire
